/* rtl/bff_pkg.sv */
// ----------------------------------------------------------------------------
// bff_pkg: shared types and constants of the bitmap find-first-free block
// item layouts, operation and status codes, and defaults
// ----------------------------------------------------------------------------
`default_nettype none

package bff_pkg;

    // default capacity of the bitmap in bits
    localparam int MAX_BITS_DEFAULT = 4096;

    // width of the map size register and its reset value
    localparam int MAP_BITS_W = 13;
    localparam logic [MAP_BITS_W-1:0] MAP_BITS_RESET = 13'd4096;

    localparam int POS_W = 12;

    typedef enum logic [1:0] {
        OP_FIND  = 2'd0,
        OP_SET   = 2'd1,
        OP_CLEAR = 2'd2,
        OP_TEST  = 2'd3
    } op_t;

    typedef enum logic [1:0] {
        ST_OK      = 2'd0,
        ST_NOSPACE = 2'd1,
        ST_RANGE   = 2'd2,
        ST_UNUSED  = 2'd3
    } status_t;

    typedef struct packed {
        op_t              operation;
        logic [POS_W-1:0] bit_position;
    } req_t;

    typedef struct packed {
        status_t          status;
        logic [POS_W-1:0] found_position;
        logic             bit_was_set;
    } rsp_t;

    // outcome of searching one byte for its lowest clear bit
    typedef struct packed {
        logic       found;
        logic [2:0] bit_idx;
    } scan_hit_t;

endpackage

`default_nettype wire

/* rtl/bitmap_find_first_free_core.sv */
// ----------------------------------------------------------------------------
// bitmap_find_first_free_core: allocation bitmap with find-first-clear search
// byte-wide synchronous memory, read-modify-write sequencer, byte scanner
// ----------------------------------------------------------------------------
// The bitmap holds MAX_BITS bits as (MAX_BITS+7)/8 bytes in one synchronous
// memory; bit k lives in byte k/8 at bit k%8. Only the lowest map_bits bits
// are in use (a larger value acts as MAX_BITS). Every request item gives
// exactly one response item. Set, clear and test accept the item and read
// its byte in S_IDLE, then modify and write the byte back and form the
// response in S_EXEC. Find scans at most ceil(size/8) bytes from byte zero
// (an empty map reports no space); the memory's single read port delivers
// one byte per cycle, and the scan stops at the first byte with a clear bit
// in use. Find does not set the bit. An index at or above the size gives an
// out-of-range status and leaves the map alone. After reset a clearing pass
// writes zero to every byte; requests stall meanwhile, the size register
// can be written at any time. A new request is taken while the previous
// response still waits at the output register. The size register should
// only be written while no request is in flight.
// ----------------------------------------------------------------------------
`default_nettype none

module bitmap_find_first_free_core
    import bff_pkg::*;
#(
    parameter int MAX_BITS = MAX_BITS_DEFAULT
)
(
    input  logic                  clk,
    input  logic                  rst_n,

    // size register write channel
    input  logic                  cfg_valid,
    output logic                  cfg_ready,
    input  logic [MAP_BITS_W-1:0] cfg_data,

    // request items
    input  logic                  req_valid,
    output logic                  req_stall,
    input  req_t                  req_item,

    // response items
    output logic                  rsp_valid,
    input  logic                  rsp_stall,
    output rsp_t                  rsp_item
);

    // memory geometry
    localparam int STORE_BYTES = (MAX_BITS + 7) / 8;
    localparam int AW          = (STORE_BYTES > 1) ? $clog2(STORE_BYTES) : 1;
    // width that holds both a byte count of the size and a byte index
    localparam int NBW         = MAP_BITS_W + 1 - 3;
    localparam int XW          = (AW + 1 > NBW) ? AW + 1 : NBW;
    // width that compares the size register against the capacity
    localparam int MBW         = $clog2(MAX_BITS + 1);
    localparam int CMPW        = (MBW > MAP_BITS_W) ? MBW : MAP_BITS_W;

    localparam logic [AW-1:0] LAST_ADDR = AW'(STORE_BYTES - 1);

    typedef enum logic [2:0] {
        S_CLEAR,
        S_IDLE,
        S_EXEC,
        S_SCAN,
        S_WAIT
    } state_t;

    // bitmap memory
    logic [7:0] mem [STORE_BYTES];

    state_t                state_reg;
    logic [MAP_BITS_W-1:0] map_bits_reg;
    op_t                   op_reg;
    logic [POS_W-1:0]      idx_reg;
    logic [AW-1:0]         scan_idx_reg;
    logic [AW-1:0]         clr_idx_reg;
    rsp_t                  hold_reg;
    logic                  rsp_valid_reg;
    rsp_t                  rsp_reg;
    logic [7:0]            rd_data_reg;

    logic [MAP_BITS_W-1:0] size;
    logic [NBW-1:0]        nbytes;
    logic [XW-1:0]         last_x;
    logic [XW-1:0]         scan_x;
    logic                  at_last;
    logic [7:0]            scan_mask;
    scan_hit_t             hit;

    logic                  req_accept;
    logic                  req_in_range;
    logic                  idx_in_range;
    logic [7:0]            bit_mask;

    logic                  wr_en;
    logic [AW-1:0]         wr_addr;
    logic [7:0]            wr_data;
    logic                  rd_en;
    logic [AW-1:0]         rd_addr;

    logic                  res_ready;
    rsp_t                  res;
    logic                  scan_more;
    logic                  rsp_free;
    logic                  rsp_load;

    // size in use, clipped to the capacity
    assign size = (CMPW'(map_bits_reg) > CMPW'(MAX_BITS)) ? MAP_BITS_W'(MAX_BITS)
                                                          : map_bits_reg;

    // bytes that hold bits in use, and the index of the last of them
    assign nbytes  = NBW'((MAP_BITS_W + 1)'(size) + (MAP_BITS_W + 1)'(7) >> 3);
    assign last_x  = XW'(nbytes) - XW'(1);
    assign scan_x  = XW'(scan_idx_reg);
    assign at_last = (scan_x == last_x);

    // a partial last byte only offers its low size%8 bits
    assign scan_mask = (at_last && (size[2:0] != 3'd0))
                     ? ((8'h01 << size[2:0]) - 8'h01) : 8'hff;

    bff_byte_scan u_scan (
        .byte_data (rd_data_reg),
        .byte_mask (scan_mask),
        .hit       (hit)
    );

    // handshakes
    assign cfg_ready  = 1'b1;
    assign req_stall  = (state_reg != S_IDLE);
    assign req_accept = req_valid && !req_stall;
    assign rsp_free   = !rsp_valid_reg || !rsp_stall;
    assign rsp_valid  = rsp_valid_reg;
    assign rsp_item   = rsp_reg;

    assign req_in_range = (MAP_BITS_W'(req_item.bit_position) < size);
    assign idx_in_range = (MAP_BITS_W'(idx_reg) < size);
    assign bit_mask     = 8'h01 << idx_reg[2:0];

    // result of the current step, memory accesses
    always_comb
    begin
        res_ready = 1'b0;
        res       = '{status: ST_OK, found_position: '0, bit_was_set: 1'b0};
        scan_more = 1'b0;
        wr_en     = 1'b0;
        wr_addr   = idx_reg[POS_W-1:3] > 0 ? AW'(idx_reg[POS_W-1:3]) : '0;
        wr_data   = rd_data_reg;
        rd_en     = 1'b0;
        rd_addr   = AW'(scan_x + XW'(1));

        unique case (state_reg)
            S_CLEAR:
            begin
                // clearing pass, one byte per cycle
                wr_en   = 1'b1;
                wr_addr = clr_idx_reg;
                wr_data = 8'h00;
            end
            S_IDLE:
            begin
                // fetch the addressed byte if in range, or byte zero for a search
                if (req_accept)
                begin
                    if (req_item.operation == OP_FIND)
                    begin
                        rd_en   = 1'b1;
                        rd_addr = '0;
                    end
                    else if (req_in_range)
                    begin
                        rd_en   = 1'b1;
                        rd_addr = AW'(req_item.bit_position[POS_W-1:3]);
                    end
                end
            end
            S_EXEC:
            begin
                // read-modify-write of one bit, or a test that only reads it
                res_ready = 1'b1;
                if (!idx_in_range)
                begin
                    res.status = ST_RANGE;
                end
                else
                begin
                    unique case (op_reg)
                        OP_SET:
                        begin
                            wr_en   = 1'b1;
                            wr_data = rd_data_reg | bit_mask;
                        end
                        OP_CLEAR:
                        begin
                            wr_en   = 1'b1;
                            wr_data = rd_data_reg & ~bit_mask;
                        end
                        OP_TEST:
                        begin
                            res.bit_was_set = |(rd_data_reg & bit_mask);
                        end
                        OP_FIND:
                        begin
                            res.status = ST_OK;
                        end
                    endcase
                end
            end
            S_SCAN:
            begin
                // one byte per cycle until a clear bit or the last byte
                priority if (nbytes == '0)
                begin
                    res_ready  = 1'b1;
                    res.status = ST_NOSPACE;
                end
                else if (hit.found)
                begin
                    res_ready          = 1'b1;
                    res.found_position = POS_W'({scan_idx_reg, hit.bit_idx});
                end
                else if (at_last)
                begin
                    res_ready  = 1'b1;
                    res.status = ST_NOSPACE;
                end
                else
                begin
                    scan_more = 1'b1;
                    rd_en     = 1'b1;
                end
            end
            S_WAIT:
            begin
                res_ready = 1'b1;
                res       = hold_reg;
            end
            default:
            begin
                res_ready = 1'b0;
            end
        endcase
    end

    assign rsp_load = res_ready && rsp_free;

    // bitmap memory, one write and one registered read per cycle
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    // sequencer, size register and response register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_CLEAR;
            map_bits_reg  <= MAP_BITS_RESET;
            op_reg        <= OP_FIND;
            idx_reg       <= '0;
            scan_idx_reg  <= '0;
            clr_idx_reg   <= '0;
            hold_reg      <= '0;
            rsp_valid_reg <= 1'b0;
            rsp_reg       <= '0;
        end
        else
        begin
            if (cfg_valid && cfg_ready)
            begin
                map_bits_reg <= cfg_data;
            end

            // response register
            if (rsp_load)
            begin
                rsp_valid_reg <= 1'b1;
                rsp_reg       <= res;
            end
            else if (!rsp_stall)
            begin
                rsp_valid_reg <= 1'b0;
            end

            unique case (state_reg)
                S_CLEAR:
                begin
                    clr_idx_reg <= clr_idx_reg + AW'(1);
                    if (clr_idx_reg == LAST_ADDR)
                    begin
                        state_reg <= S_IDLE;
                    end
                end
                S_IDLE:
                begin
                    if (req_accept)
                    begin
                        op_reg       <= req_item.operation;
                        idx_reg      <= req_item.bit_position;
                        scan_idx_reg <= '0;
                        state_reg    <= (req_item.operation == OP_FIND) ? S_SCAN : S_EXEC;
                    end
                end
                S_EXEC, S_SCAN, S_WAIT:
                begin
                    if (scan_more)
                    begin
                        scan_idx_reg <= scan_idx_reg + AW'(1);
                    end
                    else if (rsp_load)
                    begin
                        state_reg <= S_IDLE;
                    end
                    else
                    begin
                        // output still occupied: park the response
                        hold_reg  <= res;
                        state_reg <= S_WAIT;
                    end
                end
                default:
                begin
                    state_reg <= S_IDLE;
                end
            endcase
        end
    end

    // no request slips in while the memory is being cleared
    a_clear_blocks_req: assert property (
        @(posedge clk) disable iff (!rst_n)
        (state_reg == S_CLEAR) |-> req_stall
    ) else $error("request accepted during clearing pass");

    // the scan never runs past the bytes in use
    a_scan_bound: assert property (
        @(posedge clk) disable iff (!rst_n)
        (state_reg == S_SCAN && nbytes != '0) |-> (XW'(scan_idx_reg) <= last_x)
    ) else $error("scan index beyond size");

    // a bit update only happens for an index in range
    a_write_in_range: assert property (
        @(posedge clk) disable iff (!rst_n)
        (state_reg == S_EXEC && wr_en) |-> idx_in_range
    ) else $error("bitmap written for out-of-range index");

    // a failed operation reports no position and no bit value
    a_fail_fields_zero: assert property (
        @(posedge clk) disable iff (!rst_n)
        (rsp_valid_reg && rsp_reg.status != ST_OK)
            |-> (rsp_reg.found_position == '0 && !rsp_reg.bit_was_set)
    ) else $error("nonzero fields on failed response");

    // a result is written back in the cycle after the read it depends on
    a_exec_after_idle: assert property (
        @(posedge clk) disable iff (!rst_n)
        (state_reg == S_EXEC) |-> ($past(state_reg) == S_IDLE)
    ) else $error("read-modify-write without preceding read");

endmodule

`default_nettype wire

/* rtl/bff_byte_scan.sv */
// ----------------------------------------------------------------------------
// bff_byte_scan: lowest clear bit of one bitmap byte
// bits outside the mask count as set and are never reported
// ----------------------------------------------------------------------------
`default_nettype none

module bff_byte_scan
    import bff_pkg::*;
(
    input  logic [7:0] byte_data,
    input  logic [7:0] byte_mask,
    output scan_hit_t  hit
);

    logic [7:0] eff;

    assign eff = byte_data | ~byte_mask;

    // walk from the top so the lowest clear bit wins
    always_comb
    begin
        hit.found   = 1'b0;
        hit.bit_idx = 3'd0;
        for (int b = 7; b >= 0; b--)
        begin
            if (!eff[b])
            begin
                hit.found   = 1'b1;
                hit.bit_idx = 3'(b);
            end
        end
    end

endmodule

`default_nettype wire
